[sv/http_request_line_parser_top_assert.svh]
// assertion macros for the request line parser
`ifndef HTTP_REQUEST_LINE_PARSER_TOP_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HRLP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("request line parser assertion failed");

// next-cycle implication
`define HRLP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("request line parser assertion failed");

`else

`define HRLP_ASSERT_IMP(label, clk, rst, ante, cons)
`define HRLP_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/hrlp_pkg.sv]
// shared types, codes and version strings of the request line parser
package hrlp_pkg;

   localparam logic [1:0] PHASE_METHOD  = 2'd0;
   localparam logic [1:0] PHASE_TARGET  = 2'd1;
   localparam logic [1:0] PHASE_VERSION = 2'd2;
   localparam logic [1:0] PHASE_UNUSED  = 2'd3;

   localparam logic [2:0] TAG_METHOD  = 3'd0;
   localparam logic [2:0] TAG_PATH    = 3'd1;
   localparam logic [2:0] TAG_QUERY   = 3'd2;
   localparam logic [2:0] TAG_VERSION = 3'd3;
   localparam logic [2:0] TAG_SEP     = 3'd4;

   localparam logic [2:0] OUT_OK         = 3'd0;
   localparam logic [2:0] OUT_NO_SPACE1  = 3'd1;
   localparam logic [2:0] OUT_NO_SPACE2  = 3'd2;
   localparam logic [2:0] OUT_METHOD_WS  = 3'd3;
   localparam logic [2:0] OUT_BAD_VER    = 3'd4;
   localparam logic [2:0] OUT_BAD_TARGET = 3'd5;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_WS_LO = 8'h09;
   localparam logic [7:0] CHAR_WS_HI = 8'h0D;

   localparam logic [3:0] VER_LEN = 4'd8;
   localparam logic [3:0] VER_POS_MAX = 4'd15;

   // parse state carried from byte to byte
   typedef struct packed {
      logic [1:0] phase;
      logic       method_has_space;
      logic       target_started;
      logic       target_bad;
      logic       in_query;
      logic [3:0] version_position;
      logic [1:0] version_match_flags;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:               PHASE_METHOD,
      method_has_space:    1'b0,
      target_started:      1'b0,
      target_bad:          1'b1,
      in_query:            1'b0,
      version_position:    4'd0,
      version_match_flags: 2'b11
   };

   // character of "HTTP/1.1" (minor_one) or "HTTP/1.0" at idx
   function automatic logic [7:0] ver_char(input logic minor_one, input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h48;
         3'd1:    c = 8'h54;
         3'd2:    c = 8'h54;
         3'd3:    c = 8'h50;
         3'd4:    c = 8'h2F;
         3'd5:    c = 8'h31;
         3'd6:    c = 8'h2E;
         3'd7:    c = minor_one ? 8'h31 : 8'h30;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[sv/hrlp_step.sv]
// per-byte tagging, state update and outcome check
module hrlp_step (
   input  hrlp_pkg::state_type cur_state,
   input  logic [7:0]          in_byte,
   input  logic                last,
   output hrlp_pkg::state_type nxt_state,
   output logic [2:0]          field_tag,
   output logic [2:0]          outcome
);

   hrlp_pkg::state_type upd;

   always_comb begin
      upd = cur_state;
      field_tag = hrlp_pkg::TAG_VERSION;
      case (cur_state.phase)
         hrlp_pkg::PHASE_METHOD: begin
            if (in_byte == hrlp_pkg::CHAR_SPACE) begin
               field_tag = hrlp_pkg::TAG_SEP;
               upd.phase = hrlp_pkg::PHASE_TARGET;
            end else begin
               field_tag = hrlp_pkg::TAG_METHOD;
               if (in_byte >= hrlp_pkg::CHAR_WS_LO && in_byte <= hrlp_pkg::CHAR_WS_HI) begin
                  upd.method_has_space = 1'b1;
               end
            end
         end
         hrlp_pkg::PHASE_TARGET: begin
            if (in_byte == hrlp_pkg::CHAR_SPACE) begin
               field_tag = hrlp_pkg::TAG_SEP;
               upd.phase = hrlp_pkg::PHASE_VERSION;
            end else begin
               if (!cur_state.target_started) begin
                  upd.target_started = 1'b1;
                  upd.target_bad = (in_byte != hrlp_pkg::CHAR_SLASH);
               end
               if (in_byte == hrlp_pkg::CHAR_QMARK && !cur_state.in_query) begin
                  field_tag = hrlp_pkg::TAG_SEP;
                  upd.in_query = 1'b1;
               end else begin
                  field_tag = cur_state.in_query ? hrlp_pkg::TAG_QUERY : hrlp_pkg::TAG_PATH;
               end
            end
         end
         default: begin
            // version phase, and the unused phase code acts the same
            field_tag = hrlp_pkg::TAG_VERSION;
            if (cur_state.version_position < hrlp_pkg::VER_LEN) begin
               if (in_byte != hrlp_pkg::ver_char(1'b1, cur_state.version_position[2:0])) begin
                  upd.version_match_flags[0] = 1'b0;
               end
               if (in_byte != hrlp_pkg::ver_char(1'b0, cur_state.version_position[2:0])) begin
                  upd.version_match_flags[1] = 1'b0;
               end
            end else begin
               upd.version_match_flags = 2'b00;
            end
            if (cur_state.version_position < hrlp_pkg::VER_POS_MAX) begin
               upd.version_position = cur_state.version_position + 4'd1;
            end
         end
      endcase
   end

   // outcome is judged on the state after this byte
   always_comb begin
      outcome = hrlp_pkg::OUT_OK;
      if (last) begin
         if (upd.phase == hrlp_pkg::PHASE_METHOD) begin
            outcome = hrlp_pkg::OUT_NO_SPACE1;
         end else if (upd.phase == hrlp_pkg::PHASE_TARGET) begin
            outcome = hrlp_pkg::OUT_NO_SPACE2;
         end else if (upd.method_has_space) begin
            outcome = hrlp_pkg::OUT_METHOD_WS;
         end else if (upd.version_position != hrlp_pkg::VER_LEN ||
                      upd.version_match_flags == 2'b00) begin
            outcome = hrlp_pkg::OUT_BAD_VER;
         end else if (upd.target_bad) begin
            outcome = hrlp_pkg::OUT_BAD_TARGET;
         end else begin
            outcome = hrlp_pkg::OUT_OK;
         end
      end
   end

   assign nxt_state = last ? hrlp_pkg::STATE_RESET : upd;

endmodule

[sv/http_request_line_parser_top.sv]
// request line parser: each byte passes through the input register and then the result register
// throughput one byte per cycle while the result register is drained; input register, step logic, result register
// the parse state advances as a byte moves from the input to the result register
// a waiting result stalls req_ready only once the input register is also full
// synchronous reset clears valid flags and returns the parse state to the method phase
`include "http_request_line_parser_top_assert.svh"

module http_request_line_parser_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_field_tag,
   output logic       rsp_line_done,
   output logic [2:0] rsp_outcome
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;
   hrlp_pkg::state_type state_ff;
   hrlp_pkg::state_type state_in;
   logic                out_valid_ff;
   logic [7:0]          out_byte_ff;
   logic [2:0]          out_tag_ff;
   logic                out_done_ff;
   logic [2:0]          out_outcome_ff;
   logic [2:0]          step_tag;
   logic [2:0]          step_outcome;
   logic                advance;
   logic                move;

   hrlp_step u_step (
      .cur_state (state_ff),
      .in_byte   (in_byte_ff),
      .last      (in_last_ff),
      .nxt_state (state_in),
      .field_tag (step_tag),
      .outcome   (step_outcome)
   );

   // result register free or emptying this cycle
   assign advance   = !out_valid_ff || rsp_ready;
   assign move      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hrlp_pkg::STATE_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (move) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last;
      end
      if (move) begin
         out_byte_ff    <= in_byte_ff;
         out_tag_ff     <= step_tag;
         out_done_ff    <= in_last_ff;
         out_outcome_ff <= step_outcome;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_field_tag = out_tag_ff;
   assign rsp_line_done = out_done_ff;
   assign rsp_outcome   = out_outcome_ff;

   `HRLP_ASSERT_IMP(a_outcome_only_on_done, clock, reset,
      rsp_valid && !rsp_line_done, rsp_outcome == hrlp_pkg::OUT_OK)
   `HRLP_ASSERT_NXT(a_state_reset_after_line, clock, reset,
      move && in_last_ff,
      state_ff.phase == hrlp_pkg::PHASE_METHOD && state_ff.version_position == 4'd0)
   `HRLP_ASSERT_IMP(a_tag_range, clock, reset,
      rsp_valid, rsp_field_tag <= hrlp_pkg::TAG_SEP)
   `HRLP_ASSERT_IMP(a_phase_reachable, clock, reset,
      1'b1, state_ff.phase != hrlp_pkg::PHASE_UNUSED)

endmodule

[verif/tb_top.sv]
// self-checking testbench for the http request line parser: directed table then random lines
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned HOLDOFF_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned DRAIN_CYCLES   = 10;
   localparam int unsigned RANDOM_ITEMS   = 1150;
   localparam int unsigned DIR_ROW_COUNT  = 24;

   localparam logic [63:0] VER_11_STR = "HTTP/1.1";
   localparam logic [63:0] VER_10_STR = "HTTP/1.0";

   typedef struct packed {
      logic [7:0] data;
      logic [2:0] tag;
      logic       done;
      logic [2:0] outcome;
   } line_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic [2:0] tag;
      logic [2:0] outcome;
   } dir_row_type;

   // typed rows: single-byte lines and the line " / ", each checked as given; the rest go through the predictor
   localparam dir_row_type DIR_ROWS [DIR_ROW_COUNT] = '{
      '{8'hFF, 1'b1, 1'b1, hrlp_pkg::TAG_METHOD, hrlp_pkg::OUT_NO_SPACE1},
      '{8'h00, 1'b1, 1'b1, hrlp_pkg::TAG_METHOD, hrlp_pkg::OUT_NO_SPACE1},
      '{8'h20, 1'b1, 1'b1, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_NO_SPACE2},
      '{8'h20, 1'b0, 1'b1, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h2F, 1'b0, 1'b1, hrlp_pkg::TAG_PATH,   hrlp_pkg::OUT_OK},
      '{8'h20, 1'b1, 1'b1, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_BAD_VER},
      // second question mark inside the target
      '{8'h20, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h2F, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h3F, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h3F, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h20, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h78, 1'b1, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      // empty method, query, version 1.0
      '{8'h20, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h2F, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h3F, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h20, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h48, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h54, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h54, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h50, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h2F, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h31, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h2E, 1'b0, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK},
      '{8'h30, 1'b1, 1'b0, hrlp_pkg::TAG_SEP,    hrlp_pkg::OUT_OK}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_field_tag;
   logic       rsp_line_done;
   logic [2:0] rsp_outcome;

   hrlp_pkg::state_type parse_st = hrlp_pkg::STATE_RESET;
   line_beat_type       expected_q [$];
   int unsigned         error_count = 0;
   int unsigned         items_sent = 0;
   int unsigned         send_idle_pct = 8;
   int unsigned         recv_idle_pct = 68;
   int unsigned         stall_cycles = 0;
   logic                holdoff_armed = 1'b0;

   http_request_line_parser_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_field_tag (rsp_field_tag),
      .rsp_line_done (rsp_line_done),
      .rsp_outcome   (rsp_outcome)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // tags one byte and advances the parse state, outcome on the last byte
   function automatic line_beat_type parse_byte(input logic [7:0] b, input logic last);
      line_beat_type r;
      r.data    = b;
      r.done    = last;
      r.outcome = hrlp_pkg::OUT_OK;
      case (parse_st.phase)
         hrlp_pkg::PHASE_METHOD: begin
            if (b == hrlp_pkg::CHAR_SPACE) begin
               r.tag = hrlp_pkg::TAG_SEP;
               parse_st.phase = hrlp_pkg::PHASE_TARGET;
            end else begin
               r.tag = hrlp_pkg::TAG_METHOD;
               if (b >= hrlp_pkg::CHAR_WS_LO && b <= hrlp_pkg::CHAR_WS_HI)
                  parse_st.method_has_space = 1'b1;
            end
         end
         hrlp_pkg::PHASE_TARGET: begin
            if (b == hrlp_pkg::CHAR_SPACE) begin
               r.tag = hrlp_pkg::TAG_SEP;
               parse_st.phase = hrlp_pkg::PHASE_VERSION;
            end else begin
               if (!parse_st.target_started) begin
                  parse_st.target_started = 1'b1;
                  parse_st.target_bad = (b != hrlp_pkg::CHAR_SLASH);
               end
               if (b == hrlp_pkg::CHAR_QMARK && !parse_st.in_query) begin
                  r.tag = hrlp_pkg::TAG_SEP;
                  parse_st.in_query = 1'b1;
               end else begin
                  r.tag = parse_st.in_query ? hrlp_pkg::TAG_QUERY : hrlp_pkg::TAG_PATH;
               end
            end
         end
         // the unused phase behaves as the version phase
         default: begin
            r.tag = hrlp_pkg::TAG_VERSION;
            if (parse_st.version_position < hrlp_pkg::VER_LEN) begin
               if (b != VER_11_STR[8*(7-parse_st.version_position[2:0]) +: 8])
                  parse_st.version_match_flags &= 2'b10;
               if (b != VER_10_STR[8*(7-parse_st.version_position[2:0]) +: 8])
                  parse_st.version_match_flags &= 2'b01;
            end else begin
               parse_st.version_match_flags = 2'b00;
            end
            if (parse_st.version_position < hrlp_pkg::VER_POS_MAX)
               parse_st.version_position = parse_st.version_position + 4'd1;
         end
      endcase
      if (last) begin
         if (parse_st.phase == hrlp_pkg::PHASE_METHOD) r.outcome = hrlp_pkg::OUT_NO_SPACE1;
         else if (parse_st.phase == hrlp_pkg::PHASE_TARGET)
            r.outcome = hrlp_pkg::OUT_NO_SPACE2;
         else if (parse_st.method_has_space) r.outcome = hrlp_pkg::OUT_METHOD_WS;
         else if (parse_st.version_position != hrlp_pkg::VER_LEN ||
                  parse_st.version_match_flags == 2'b00)
            r.outcome = hrlp_pkg::OUT_BAD_VER;
         else if (parse_st.target_bad) r.outcome = hrlp_pkg::OUT_BAD_TARGET;
         else r.outcome = hrlp_pkg::OUT_OK;
         parse_st = hrlp_pkg::STATE_RESET;
      end
      return r;
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic last, input logic typed,
                            input line_beat_type typed_exp);
      line_beat_type pred;
      logic          accepted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_last    <= last;
      accepted = 1'b0;
      // ready is stable at the falling edge and holds through the next rising edge
      while (!accepted) begin
         @(negedge clock);
         accepted = req_ready;
         @(posedge clock);
      end
      pred = parse_byte(b, last);
      expected_q = {expected_q, typed ? typed_exp : pred};
      items_sent++;
   endtask

   function automatic logic [7:0] rand_non_space();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == hrlp_pkg::CHAR_SPACE);
      return b;
   endfunction

   // mostly well-formed lines with random content, some noise and cut-off lines
   task automatic send_random_line();
      logic [7:0]  line_bytes [$];
      logic [63:0] ver_str;
      int unsigned kind;
      int unsigned len;
      int unsigned cut;
      kind = $urandom_range(99);
      if (kind < 8) begin
         len = $urandom_range(12, 1);
         repeat (len) line_bytes = {line_bytes, 8'($urandom_range(255))};
      end else begin
         len = $urandom_range(7);
         repeat (len) begin
            if ($urandom_range(9) == 0)
               line_bytes = {line_bytes,
                             8'($urandom_range(hrlp_pkg::CHAR_WS_HI, hrlp_pkg::CHAR_WS_LO))};
            else
               line_bytes = {line_bytes, 8'($urandom_range(8'h5A, 8'h41))};
         end
         line_bytes = {line_bytes, hrlp_pkg::CHAR_SPACE};
         if ($urandom_range(19) != 0) begin
            line_bytes = {line_bytes,
                          ($urandom_range(9) != 0) ? hrlp_pkg::CHAR_SLASH : rand_non_space()};
            len = $urandom_range(10);
            repeat (len) begin
               case ($urandom_range(5))
                  0:       line_bytes = {line_bytes, hrlp_pkg::CHAR_QMARK};
                  1:       line_bytes = {line_bytes, rand_non_space()};
                  default: line_bytes = {line_bytes, 8'($urandom_range(8'h7E, 8'h21))};
               endcase
            end
         end
         line_bytes = {line_bytes, hrlp_pkg::CHAR_SPACE};
         ver_str = ($urandom_range(1) == 0) ? VER_11_STR : VER_10_STR;
         len = 8;
         if ($urandom_range(4) == 0) begin
            case ($urandom_range(2))
               0: len = $urandom_range(7);
               1: len = 8 + $urandom_range(8, 1);
               default: ver_str[8*$urandom_range(7) +: 8] = 8'($urandom_range(255));
            endcase
         end
         for (int i = 0; i < len; i++)
            line_bytes = {line_bytes,
                          (i < 8) ? ver_str[8*(7-i) +: 8] : 8'($urandom_range(255))};
         if ($urandom_range(9) == 0) begin
            cut = $urandom_range(line_bytes.size(), 1);
            while (line_bytes.size() > cut) void'(line_bytes.pop_back());
         end
      end
      foreach (line_bytes[i])
         send_beat(line_bytes[i], i == line_bytes.size() - 1, 1'b0, '0);
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (act_v !== exp_v) begin
         error_count++;
         $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      end
   endtask

   // receiver: checks the beat taken at the coming edge, then picks rsp_ready at that edge
   initial begin : receiver
      line_beat_type want;
      int unsigned   holdoff_left;
      logic          holdoff_done;
      holdoff_left = 0;
      holdoff_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               error_count++;
               $display("%0t unexpected beat expected none actual %h %h %b %h", $time,
                        rsp_out_byte, rsp_field_tag, rsp_line_done, rsp_outcome);
            end else begin
               want = expected_q.pop_front();
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("field_tag", 8'(want.tag), 8'(rsp_field_tag));
               check_field("line_done", 8'(want.done), 8'(rsp_line_done));
               check_field("outcome", 8'(want.outcome), 8'(rsp_outcome));
            end
         end
         @(posedge clock);
         if (holdoff_armed && !holdoff_done) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // handshakes are sampled at the falling edge where nothing is changing
   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      line_beat_type typed_exp;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIR_ROW_COUNT; i++) begin
         typed_exp = '{DIR_ROWS[i].data, DIR_ROWS[i].tag, DIR_ROWS[i].last,
                       DIR_ROWS[i].outcome};
         send_beat(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed, typed_exp);
      end
      while (items_sent < DIR_ROW_COUNT + RANDOM_ITEMS / 3) send_random_line();
      send_idle_pct = 68;
      recv_idle_pct = 8;
      while (items_sent < DIR_ROW_COUNT + 2 * RANDOM_ITEMS / 3) send_random_line();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long receiver hold-off while the sender keeps offering beats
      holdoff_armed <= 1'b1;
      while (items_sent < DIR_ROW_COUNT + RANDOM_ITEMS) send_random_line();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
